[rtl/etfp_pkg.sv]
// Shared types, constants and helpers for the escape-time fractal pixel unit.
`timescale 1ns / 1ps

package etfp_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_COLUMNS_DEFAULT   = 4096;
    localparam int MAX_ROWS_DEFAULT      = 4096;
    localparam int FRACTION_BITS_DEFAULT = 28;

    // Configuration port layout.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_EDGE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_EDGE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_X         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ABORT_RADIUS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 3'd5;

    // Register reset values.
    localparam logic signed [31:0] LEFT_EDGE_RST      = -32'sd536870912;
    localparam logic signed [31:0] TOP_EDGE_RST       = 32'sd268435456;
    localparam logic [30:0]        STEP_X_RST         = 31'd262144;
    localparam logic [30:0]        STEP_Y_RST         = 31'd262144;
    localparam logic [30:0]        ABORT_RADIUS_RST   = 31'd536870912;
    localparam logic [15:0]        MAX_ITERATIONS_RST = 16'd255;

    // Color divider: every quotient is below 256, numerators fit in 29 bits.
    localparam int QUO_BITS = 8;
    localparam int DIV_W    = 29;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_RAD,
        ST_INIT,
        ST_XY,
        ST_NEW,
        ST_SQR,
        ST_SQI,
        ST_MAG,
        ST_DLOAD,
        ST_DSTEP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        COL_BLUE,
        COL_RED,
        COL_GREEN
    } color_t;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'(INT32_MAX))
        begin
            r = INT32_MAX;
        end
        else if (v < 65'(INT32_MIN))
        begin
            r = INT32_MIN;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/escape_time_fractal_pixel_unit.sv]
// Top level of the escape-time fractal pixel unit: sequencer, shared multiplier, divider.
`timescale 1ns / 1ps

// Usage:
// A beat on the input channel (column, row) starts one pixel. The unit forms the
// point c from the configuration registers, iterates z = z*z - c on one shared
// 32x32 multiplier and then derives the colors with a shared restoring divider.
// in_ready is high only while the unit is idle; one pixel is in work at a time.
// The unit forms c_re, c_im and the squared abort radius on the multiplier,
// clears z, then runs n iterations, where n is count + 1 on escape and
// max_iterations otherwise. Each iteration steps through five states
// (XY, NEW, SQR, SQI, MAG) because it needs three products from the single
// multiplier plus the update and the magnitude compare. Then each color is got
// from a divider load and its quotient steps, and a last step moves the result
// into the output register.
// The result sits in an output register; a new pixel is accepted while it waits,
// and a finished pixel waits in its last step until the receiver takes the old
// beat. The configuration port is always ready and must only be written while
// idle. Reset loads the register defaults and empties the output register.
module escape_time_fractal_pixel_unit
    import etfp_pkg::*;
#(
    parameter int MAX_COLUMNS   = MAX_COLUMNS_DEFAULT,
    parameter int MAX_ROWS      = MAX_ROWS_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [11:0]            column,
    input  logic [11:0]            row,
    // output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            iteration_count,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [16:0] ColLimit = 17'(MAX_COLUMNS - 1);
    localparam logic [16:0] RowLimit = 17'(MAX_ROWS - 1);

    state_t state_reg, state_next;
    color_t sel_reg, sel_next;

    logic signed [31:0] left_edge_reg, left_edge_next;
    logic signed [31:0] top_edge_reg, top_edge_next;
    logic [30:0]        step_x_reg, step_x_next;
    logic [30:0]        step_y_reg, step_y_next;
    logic [30:0]        radius_reg, radius_next;
    logic [15:0]        max_iter_reg, max_iter_next;

    logic [16:0]        col_reg, col_next;
    logic [16:0]        row_reg, row_next;
    logic signed [31:0] c_re_reg, c_re_next;
    logic signed [31:0] c_im_reg, c_im_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [61:0]        r2_reg, r2_next;
    logic signed [31:0] zr_reg, zr_next;
    logic signed [31:0] zi_reg, zi_next;
    logic signed [63:0] zr_sq_reg, zr_sq_next;
    logic signed [63:0] zi_sq_reg, zi_sq_next;
    logic [15:0]        count_reg, count_next;

    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    den_reg, den_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [2:0]          bit_reg, bit_next;
    logic [7:0]          red_res_reg, red_res_next;
    logic [7:0]          green_res_reg, green_res_next;
    logic [7:0]          blue_res_reg, blue_res_next;

    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_count_reg, out_count_next;
    logic [7:0]         out_red_reg, out_red_next;
    logic [7:0]         out_green_reg, out_green_next;
    logic [7:0]         out_blue_reg, out_blue_next;

    // Shared multiplier.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    // Iteration datapath.
    logic signed [63:0] diff_sq, sh_re, sh_im;
    logic signed [31:0] nr, ni;
    logic [63:0]        mag;
    logic [16:0]        count_inc;

    // Color divider.
    logic [15:0]         v_val;
    logic                ge;
    logic [QUO_BITS-1:0] quo_step;
    logic [7:0]          color_val;

    assign mul_p = mul_a * mul_b;

    assign diff_sq   = zr_sq_reg - zi_sq_reg;
    assign sh_re     = diff_sq >>> FRACTION_BITS;
    assign sh_im     = prod_reg >>> (FRACTION_BITS - 1);
    assign nr        = sat32(65'(sh_re) - 65'(c_re_reg));
    assign ni        = sat32(65'(sh_im) - 65'(c_im_reg));
    assign mag       = 64'($unsigned(zr_sq_reg)) + 64'($unsigned(zi_sq_reg));
    assign count_inc = 17'(count_reg) + 17'd1;

    assign v_val     = max_iter_reg - count_reg;
    assign ge        = (rem_reg >= den_reg);
    assign quo_step  = {quo_reg[QUO_BITS-2:0], ge};
    assign color_val = (max_iter_reg == 16'd0) ? 8'd0 : quo_step;

    assign in_ready        = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign iteration_count = out_count_reg;
    assign red             = out_red_reg;
    assign green           = out_green_reg;
    assign blue            = out_blue_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        left_edge_next = left_edge_reg;
        top_edge_next  = top_edge_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        radius_next    = radius_reg;
        max_iter_next  = max_iter_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        c_re_next      = c_re_reg;
        c_im_next      = c_im_reg;
        prod_next      = prod_reg;
        r2_next        = r2_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        zr_sq_next     = zr_sq_reg;
        zi_sq_next     = zi_sq_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        red_res_next   = red_res_reg;
        green_res_next = green_res_reg;
        blue_res_next  = blue_res_reg;
        out_count_next = out_count_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_a          = '0;
        mul_b          = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEFT_EDGE:      left_edge_next = $signed(cfg_data);
                REG_TOP_EDGE:       top_edge_next  = $signed(cfg_data);
                REG_STEP_X:         step_x_next    = cfg_data[30:0];
                REG_STEP_Y:         step_y_next    = cfg_data[30:0];
                REG_ABORT_RADIUS:   radius_next    = cfg_data[30:0];
                REG_MAX_ITERATIONS: max_iter_next  = cfg_data[15:0];
                default:            ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    col_next   = ({5'd0, column} > ColLimit) ? ColLimit : {5'd0, column};
                    row_next   = ({5'd0, row} > RowLimit) ? RowLimit : {5'd0, row};
                    state_next = ST_CRE;
                end
            end
            ST_CRE:
            begin
                mul_a      = 32'(col_reg);
                mul_b      = 32'(step_x_reg);
                prod_next  = mul_p;
                state_next = ST_CIM;
            end
            ST_CIM:
            begin
                c_re_next  = sat32(65'(left_edge_reg) + 65'(prod_reg));
                mul_a      = 32'(row_reg);
                mul_b      = 32'(step_y_reg);
                prod_next  = mul_p;
                state_next = ST_RAD;
            end
            ST_RAD:
            begin
                c_im_next  = sat32(65'(top_edge_reg) - 65'(prod_reg));
                mul_a      = 32'(radius_reg);
                mul_b      = 32'(radius_reg);
                prod_next  = mul_p;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                r2_next    = prod_reg[61:0];
                zr_next    = '0;
                zi_next    = '0;
                zr_sq_next = '0;
                zi_sq_next = '0;
                count_next = '0;
                sel_next   = COL_BLUE;
                state_next = (max_iter_reg == 16'd0) ? ST_DLOAD : ST_XY;
            end
            ST_XY:
            begin
                mul_a      = zr_reg;
                mul_b      = zi_reg;
                prod_next  = mul_p;
                state_next = ST_NEW;
            end
            ST_NEW:
            begin
                zr_next    = nr;
                zi_next    = ni;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                mul_a      = zr_reg;
                mul_b      = zr_reg;
                zr_sq_next = mul_p;
                state_next = ST_SQI;
            end
            ST_SQI:
            begin
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                zi_sq_next = mul_p;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                sel_next = COL_BLUE;
                if (mag >= {2'd0, r2_reg})
                begin
                    state_next = ST_DLOAD;
                end
                else
                begin
                    count_next = count_inc[15:0];
                    state_next = (count_inc >= {1'b0, max_iter_reg}) ? ST_DLOAD : ST_XY;
                end
            end
            ST_DLOAD:
            begin
                // The quotient is below 256, so the divisor starts seven places up.
                unique case (sel_reg)
                    COL_BLUE:
                    begin
                        rem_next = DIV_W'(v_val) * DIV_W'(255);
                        den_next = DIV_W'(max_iter_reg) << (QUO_BITS - 1);
                    end
                    COL_RED:
                    begin
                        rem_next = DIV_W'(v_val) * DIV_W'(2550);
                        den_next = (DIV_W'(max_iter_reg) * DIV_W'(11)) << (QUO_BITS - 1);
                    end
                    COL_GREEN:
                    begin
                        rem_next = DIV_W'(v_val) * DIV_W'(5100);
                        den_next = (DIV_W'(max_iter_reg) * DIV_W'(21)) << (QUO_BITS - 1);
                    end
                    default:
                    begin
                        rem_next = '0;
                        den_next = '0;
                    end
                endcase
                bit_next   = '0;
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                rem_next = ge ? (rem_reg - den_reg) : rem_reg;
                den_next = den_reg >> 1;
                quo_next = quo_step;
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'(QUO_BITS - 1))
                begin
                    unique case (sel_reg)
                        COL_BLUE:
                        begin
                            blue_res_next = color_val;
                            sel_next      = COL_RED;
                            state_next    = ST_DLOAD;
                        end
                        COL_RED:
                        begin
                            red_res_next = color_val;
                            sel_next     = COL_GREEN;
                            state_next   = ST_DLOAD;
                        end
                        COL_GREEN:
                        begin
                            green_res_next = color_val;
                            state_next     = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_red_next   = red_res_reg;
                    out_green_next = green_res_reg;
                    out_blue_next  = blue_res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= COL_BLUE;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
            left_edge_reg <= LEFT_EDGE_RST;
            top_edge_reg  <= TOP_EDGE_RST;
            step_x_reg    <= STEP_X_RST;
            step_y_reg    <= STEP_Y_RST;
            radius_reg    <= ABORT_RADIUS_RST;
            max_iter_reg  <= MAX_ITERATIONS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            left_edge_reg <= left_edge_next;
            top_edge_reg  <= top_edge_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            radius_reg    <= radius_next;
            max_iter_reg  <= max_iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        row_reg       <= row_next;
        c_re_reg      <= c_re_next;
        c_im_reg      <= c_im_next;
        prod_reg      <= prod_next;
        r2_reg        <= r2_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        zr_sq_reg     <= zr_sq_next;
        zi_sq_reg     <= zi_sq_next;
        count_reg     <= count_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        quo_reg       <= quo_next;
        red_res_reg   <= red_res_next;
        green_res_reg <= green_res_next;
        blue_res_reg  <= blue_res_next;
        out_count_reg <= out_count_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
    end

endmodule

[rtl/etfp_checker.sv]
// Port-level assertions for the escape-time fractal pixel unit, bound to the top level.
`timescale 1ns / 1ps

module etfp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       cfg_ready,
    input logic [15:0] iteration_count,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);

    // One pixel is in work at a time, so taking a beat closes the input.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open right after a beat was taken");

    // The color scales are 255/1.1, 255/1.05 and 255 of the same fraction.
    a_color_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red <= green) && (green <= blue))
        else $error("color channels out of order");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(iteration_count)
            && $stable(red) && $stable(green) && $stable(blue))
        else $error("stalled result beat changed");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind escape_time_fractal_pixel_unit etfp_checker u_etfp_checker (.*);
